>>> design/mts_pkg.sv
// Shared types and codes for the min-tracking stack.
`timescale 1ns / 1ps
`default_nettype none
package mts_pkg;

  // Default number of stack entries
  localparam int DEFAULT_STACK_DEPTH = 1024;

  // Request codes
  localparam logic [1:0] REQ_READ = 2'd0;
  localparam logic [1:0] REQ_PUSH = 2'd1;
  localparam logic [1:0] REQ_POP  = 2'd2;

  // Fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_FULL  = 2'd1;
  localparam logic [1:0] FAULT_EMPTY = 2'd2;

  // One stack entry: value and running minimum down to the bottom
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] min_value;
  } entry_t;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage
`default_nettype wire

>>> design/min_tracking_stack_top.sv
// Top level of the min-tracking stack: cell chain, entry count, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  request | in        | in_valid / in_ready  | req_type, push_value
//  result  | out       | out_valid / out_ready| top_value, min_value, depth, is_empty, fault
//
// A result beat appears the cycle after its request beat.
// The top entry always sits in cell 0, so a push or pop is one shift of the whole chain.
// in_ready is high while the result register is empty or its beat is being taken,
// so one request per cycle is sustained; a stalled result stalls requests.
// Reset clears the entry count and the result valid; cell contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none
module min_tracking_stack_top #(
  parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] push_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      top_value,
  output logic signed [31:0]      min_value,
  output logic [CW-1:0]           depth,
  output logic                    is_empty,
  output logic [1:0]              fault
);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                fire;
  logic                full;
  logic                do_push;
  logic                do_pop;
  logic [1:0]          fault_next;
  mts_pkg::shift_t     ctl;
  mts_pkg::entry_t     new_entry;
  mts_pkg::entry_t     top_next;
  mts_pkg::entry_t     cells [STACK_DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign full     = (count == CW'(STACK_DEPTH));

  // Decode the request against the current count
  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    fault_next = mts_pkg::FAULT_NONE;
    unique case (req_type)
      mts_pkg::REQ_PUSH: begin
        if (full) begin
          fault_next = mts_pkg::FAULT_FULL;
        end else begin
          do_push = fire;
        end
      end
      mts_pkg::REQ_POP: begin
        if (count == '0) begin
          fault_next = mts_pkg::FAULT_EMPTY;
        end else begin
          do_pop = fire;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.push = do_push;
  assign ctl.pop  = do_pop;

  // Build the pushed entry; its minimum folds in the entry below
  always_comb begin
    new_entry.value = push_value;
    if (count != '0 && cells[0].min_value < push_value) begin
      new_entry.min_value = cells[0].min_value;
    end else begin
      new_entry.min_value = push_value;
    end
  end

  // Advance the entry count
  always_comb begin
    count_next = count;
    if (do_push) begin
      count_next = count + CW'(1);
    end else if (do_pop) begin
      count_next = count - CW'(1);
    end
  end

  // Pick the top entry as it stands after the request
  always_comb begin
    if (do_push) begin
      top_next = new_entry;
    end else if (do_pop) begin
      top_next = cells[1];
    end else begin
      top_next = cells[0];
    end
    if (count_next == '0) begin
      top_next = '0;
    end
  end

  // Chain of cells; cell 0 is the top of the stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    mts_pkg::entry_t above;
    mts_pkg::entry_t below;
    if (i == 0) begin : g_head
      assign above = new_entry;
    end else begin : g_mid
      assign above = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below = '0;
    end else begin : g_body
      assign below = cells[i+1];
    end
    mts_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .q          (cells[i])
    );
  end

  // Hold the count and the result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      top_value <= top_next.value;
      min_value <= top_next.min_value;
      depth     <= count_next;
      is_empty  <= (count_next == '0);
      fault     <= fault_next;
    end
  end

endmodule
`default_nettype wire

>>> design/mts_cell.sv
// One stack cell: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module mts_cell (
  input  wire logic           clk,
  input  wire mts_pkg::shift_t ctl,
  input  wire mts_pkg::entry_t from_above,
  input  wire mts_pkg::entry_t from_below,
  output mts_pkg::entry_t      q
);

  // Shift down on push, up on pop, hold otherwise
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q <= from_above;
    end else if (ctl.pop) begin
      q <= from_below;
    end
  end

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the min-tracking stack: scoreboard class, drivers, monitor.
`timescale 1ns / 1ps
module testbench;

  localparam int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  // Snapshot of the stack as one result beat reports it
  typedef struct packed {
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic [CW-1:0]      depth;
    logic               is_empty;
    logic [1:0]         fault;
  } stack_view_t;

  // Mirror of the stack contents and the queue of snapshots still owed by the block
  class stack_tracker;
    logic signed [31:0] value_mem [STACK_DEPTH];
    logic signed [31:0] min_mem [STACK_DEPTH];
    int unsigned entries;
    int unsigned failures;
    stack_view_t owed_views [$];

    function new();
      entries = 0;
      failures = 0;
    endfunction

    // Apply one accepted request and queue the snapshot it must produce
    function void note_request(logic [1:0] req, logic signed [31:0] val);
      stack_view_t view;
      logic signed [31:0] run_min;
      view = '0;
      view.fault = mts_pkg::FAULT_NONE;
      if (req == mts_pkg::REQ_PUSH) begin
        if (entries >= STACK_DEPTH) begin
          view.fault = mts_pkg::FAULT_FULL;
        end else begin
          run_min = val;
          if (entries > 0 && min_mem[entries-1] < val) run_min = min_mem[entries-1];
          value_mem[entries] = val;
          min_mem[entries] = run_min;
          entries++;
        end
      end else if (req == mts_pkg::REQ_POP) begin
        if (entries == 0) view.fault = mts_pkg::FAULT_EMPTY;
        else entries--;
      end
      if (entries > 0) begin
        view.top_value = value_mem[entries-1];
        view.min_value = min_mem[entries-1];
      end
      view.depth = CW'(entries);
      view.is_empty = (entries == 0);
      owed_views.push_back(view);
    endfunction

    // Compare one result beat against the oldest owed snapshot
    function void check_result(stack_view_t got);
      stack_view_t want;
      if (owed_views.size() == 0) begin
        $error("result beat with no request outstanding");
        failures++;
        return;
      end
      want = owed_views.pop_front();
      if (got.top_value !== want.top_value) begin
        $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
        failures++;
      end
      if (got.min_value !== want.min_value) begin
        $error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
        failures++;
      end
      if (got.depth !== want.depth) begin
        $error("depth: expected %0d, got %0d", want.depth, got.depth);
        failures++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
        failures++;
      end
      if (got.fault !== want.fault) begin
        $error("fault: expected %0d, got %0d", want.fault, got.fault);
        failures++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              req_type;
  logic signed [31:0]      push_value;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [31:0]      top_value;
  logic signed [31:0]      min_value;
  logic [CW-1:0]           depth;
  logic                    is_empty;
  logic [1:0]              fault;

  bit steady;
  int unsigned cycle_count;
  stack_tracker tracker = new();

  min_tracking_stack_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .top_value  (top_value),
    .min_value  (min_value),
    .depth      (depth),
    .is_empty   (is_empty),
    .fault      (fault)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stall the result side at random, except during the steady stretch
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 21);
  end

  // Record request beats and check result beats
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) tracker.note_request(req_type, push_value);
    if (!rst && out_valid && out_ready)
      tracker.check_result('{top_value, min_value, depth, is_empty, fault});
  end

  // Abort a run that hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL min_tracking_stack_top");
    $finish;
  end

  // Mix of extremes, small values that tie often, and full-range values
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3: return $signed($urandom_range(0, 16)) - 32'sd8;
      default: return $signed($urandom);
    endcase
  endfunction

  // Present one request beat, idling first at random, and hold it until taken
  task automatic issue_request(logic [1:0] req, logic signed [31:0] val);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    push_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every owed result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed_views.size() != 0) @(posedge clk);
  endtask

  // Random requests with the given push and pop shares; optionally run until full
  task automatic run_mix(int items, int push_pct, int pop_pct, bit until_full);
    int r;
    logic [1:0] req;
    for (int n = 0; n < items || (until_full && tracker.entries < STACK_DEPTH); n++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) req = mts_pkg::REQ_PUSH;
      else if (r < push_pct + pop_pct) req = mts_pkg::REQ_POP;
      else req = ($urandom_range(0, 3) == 0) ? REQ_UNUSED : mts_pkg::REQ_READ;
      issue_request(req, pick_value());
    end
  endtask

  initial begin
    steady = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= mts_pkg::REQ_READ;
    push_value <= '0;
    out_ready <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty stack: read, pop on empty, unused selector
    issue_request(mts_pkg::REQ_READ, $signed($urandom));
    issue_request(mts_pkg::REQ_POP, $signed($urandom));
    issue_request(REQ_UNUSED, $signed($urandom));
    // Extremes and a new minimum on top of a larger one
    issue_request(mts_pkg::REQ_PUSH, 32'sd0);
    issue_request(mts_pkg::REQ_PUSH, VAL_MAX);
    issue_request(mts_pkg::REQ_PUSH, VAL_MIN);
    issue_request(mts_pkg::REQ_PUSH, -32'sd1);
    issue_request(mts_pkg::REQ_READ, $signed($urandom));
    issue_request(REQ_UNUSED, $signed($urandom));
    // Pop back past the minimum so the older one returns
    issue_request(mts_pkg::REQ_POP, $signed($urandom));
    issue_request(mts_pkg::REQ_POP, $signed($urandom));
    issue_request(mts_pkg::REQ_POP, $signed($urandom));
    // Alternating bit patterns and a tie on the minimum
    issue_request(mts_pkg::REQ_PUSH, 32'sh5555_5555);
    issue_request(mts_pkg::REQ_PUSH, 32'shaaaa_aaaa);
    issue_request(mts_pkg::REQ_PUSH, 32'shaaaa_aaaa);
    issue_request(mts_pkg::REQ_POP, $signed($urandom));
    issue_request(mts_pkg::REQ_POP, $signed($urandom));
    issue_request(mts_pkg::REQ_POP, $signed($urandom));
    issue_request(mts_pkg::REQ_POP, $signed($urandom));
    // Pop once more on the now empty stack
    issue_request(mts_pkg::REQ_POP, $signed($urandom));

    // Shallow churn around empty
    run_mix(100, 40, 40, 1'b0);

    // Hold off until the block has caught up
    drain_results();

    // Fill to full without idling on either side
    steady = 1'b1;
    run_mix(0, 96, 2, 1'b1);
    steady = 1'b0;

    // Work at the full boundary, then unwind deep entries
    run_mix(40, 60, 20, 1'b0);
    run_mix(120, 20, 70, 1'b0);

    drain_results();
    repeat (4) @(posedge clk);
    if (tracker.failures == 0 && tracker.owed_views.size() == 0) begin
      $display("PASS min_tracking_stack_top");
    end else begin
      $display("FAIL min_tracking_stack_top");
    end
    $finish;
  end

endmodule
